/* hw/rtl/i2p_pkg.sv */
// Package for the infix to postfix converter: stack sizing, character codes,
// status codes and the operator precedence function.
// No dependencies.
`default_nettype none

package i2p_pkg;

    // Operator stack sizing.
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // Characters that have a meaning of their own.
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // Status codes carried on every result of an item.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;

    // Precedence: '^' 3, '*' '/' 2, '+' '-' 1, anything else 0.
    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_CARET) begin
            p = 2'd3;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            p = 2'd2;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
        end
        return p;
    endfunction

    // True for the five binary operators.
    function automatic logic is_operator(input logic [7:0] c);
        return (c == CH_CARET) || (c == CH_STAR) || (c == CH_SLASH) ||
               (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/infix_to_postfix_converter_top.sv */
// Shunting-yard infix to postfix converter with the operator stack in a
// synchronous memory. Depends on i2p_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  input   | in        | i_in_valid / o_in_stall   | i_symbol, i_expr_last
//  output  | out       | o_out_valid / i_out_stall | o_out_char, o_has_char, o_run_last,
//          |           |                           | o_expr_end, o_status
//
// An item takes an accept step, a step on the symbol itself (push, pass-through,
// the '(' pop of a ')' or no action), a step for each character popped and emitted,
// flush included, and a step to hand on the closing result. The memory's read
// port delivers one new stack top per cycle, which sets the pop rate of one a
// cycle while the output is not stalled.
// Reset is synchronous and active low; it empties the stack and drops any
// pending result. A stalled output holds the sequencer until the register frees.
`default_nettype none

module infix_to_postfix_converter_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_symbol,
    input  wire logic       i_expr_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic      [7:0] o_out_char,
    output logic            o_has_char,
    output logic            o_run_last,
    output logic            o_expr_end,
    output logic      [1:0] o_status
);

    typedef enum logic {S_IDLE, S_RUN} t_state;
    typedef enum logic [1:0] {P_MAIN, P_FLUSH, P_FIN} t_phase;

    localparam int CW = i2p_pkg::CNT_W;
    localparam int AW = i2p_pkg::ADDR_W;

    // Operator stack memory with a registered read port.
    logic [7:0]    mem [i2p_pkg::STACK_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [AW-1:0] mem_ra;
    logic [7:0]    r_rd_q;
    logic          r_fwd;
    logic [7:0]    r_fwd_d;
    logic [7:0]    top;

    // Sequencer and stack bookkeeping.
    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_paren, n_paren;
    logic [7:0]    r_sym, n_sym;
    logic          r_last, n_last;
    logic [1:0]    r_status, n_status;
    logic          r_pend_v, n_pend_v;
    logic [7:0]    r_pend_c, n_pend_c;

    // Output register.
    logic          r_o_valid, n_o_valid;
    logic [7:0]    r_o_char, n_o_char;
    logic          r_o_has, n_o_has;
    logic          r_o_run_last, n_o_run_last;
    logic          r_o_end, n_o_end;
    logic [1:0]    r_o_status, n_o_status;

    logic          can_emit;
    logic          do_emit, do_pop, do_push, do_finish;
    logic [7:0]    emit_val;
    logic [CW-1:0] cnt_m1;
    logic          full;

    // A write and a read of the same entry in one cycle forward the new data.
    assign top      = r_fwd ? r_fwd_d : r_rd_q;
    assign can_emit = !r_o_valid || !i_out_stall;
    assign full     = (r_count == CW'(i2p_pkg::STACK_DEPTH));

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_count      = r_count;
        n_paren      = r_paren;
        n_sym        = r_sym;
        n_last       = r_last;
        n_status     = r_status;
        n_pend_v     = r_pend_v;
        n_pend_c     = r_pend_c;
        n_o_valid    = r_o_valid;
        n_o_char     = r_o_char;
        n_o_has      = r_o_has;
        n_o_run_last = r_o_run_last;
        n_o_end      = r_o_end;
        n_o_status   = r_o_status;
        do_emit      = 1'b0;
        do_pop       = 1'b0;
        do_push      = 1'b0;
        do_finish    = 1'b0;
        emit_val     = r_sym;

        // The output register empties once its item is taken.
        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // Status is settled up front from the stack fill, the stack top
                    // and the count of open parentheses on the stack.
                    n_sym    = i_symbol;
                    n_last   = i_expr_last;
                    n_phase  = P_MAIN;
                    n_pend_v = 1'b0;
                    n_state  = S_RUN;
                    n_status = i2p_pkg::ST_OK;
                    if (i_symbol == i2p_pkg::CH_LPAREN && full) begin
                        n_status = i2p_pkg::ST_OVERFLOW;
                    end else if (i2p_pkg::is_operator(i_symbol) && full &&
                                 i2p_pkg::prec_of(top) < i2p_pkg::prec_of(i_symbol)) begin
                        n_status = i2p_pkg::ST_OVERFLOW;
                    end else if (i_symbol == i2p_pkg::CH_RPAREN && r_paren == '0) begin
                        n_status = i2p_pkg::ST_UNMATCHED;
                    end
                end
            end
            S_RUN: begin
                if (can_emit) begin
                    case (r_phase)
                        P_MAIN: begin
                            // Steps for the symbol itself: pops that it forces, then its own push, pop or pass-through.
                            n_phase = r_last ? P_FLUSH : P_FIN;
                            if (r_sym == i2p_pkg::CH_LPAREN) begin
                                do_push = !full;
                            end else if (r_sym == i2p_pkg::CH_RPAREN) begin
                                if (r_count != '0) begin
                                    do_pop = 1'b1;
                                    if (top != i2p_pkg::CH_LPAREN) begin
                                        do_emit  = 1'b1;
                                        emit_val = top;
                                        n_phase  = P_MAIN;
                                    end
                                end
                            end else if (i2p_pkg::is_operator(r_sym)) begin
                                if (r_count != '0 &&
                                    i2p_pkg::prec_of(top) >= i2p_pkg::prec_of(r_sym)) begin
                                    do_pop   = 1'b1;
                                    do_emit  = 1'b1;
                                    emit_val = top;
                                    n_phase  = P_MAIN;
                                end else begin
                                    do_push = !full;
                                end
                            end else begin
                                do_emit  = 1'b1;
                                emit_val = r_sym;
                            end
                        end
                        P_FLUSH: begin
                            // End of expression: drain the stack, '(' included.
                            if (r_count != '0) begin
                                do_pop   = 1'b1;
                                do_emit  = 1'b1;
                                emit_val = top;
                            end else begin
                                do_finish = 1'b1;
                            end
                        end
                        P_FIN: begin
                            do_finish = 1'b1;
                        end
                        default: begin
                            do_finish = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Stack pointer and open parenthesis count.
        if (do_pop) begin
            n_count = r_count - CW'(1);
            if (top == i2p_pkg::CH_LPAREN) begin
                n_paren = r_paren - CW'(1);
            end
        end
        if (do_push) begin
            n_count = r_count + CW'(1);
            if (r_sym == i2p_pkg::CH_LPAREN) begin
                n_paren = r_paren + CW'(1);
            end
        end

        // A new character moves the held one out, so the last one of the
        // item can still be marked when the item closes.
        if (do_emit) begin
            if (r_pend_v) begin
                n_o_valid    = 1'b1;
                n_o_char     = r_pend_c;
                n_o_has      = 1'b1;
                n_o_run_last = 1'b0;
                n_o_end      = 1'b0;
                n_o_status   = r_status;
            end
            n_pend_v = 1'b1;
            n_pend_c = emit_val;
        end

        // Close the item with the held character or an empty marker.
        if (do_finish) begin
            n_o_valid    = 1'b1;
            n_o_char     = r_pend_v ? r_pend_c : 8'h00;
            n_o_has      = r_pend_v;
            n_o_run_last = 1'b1;
            n_o_end      = r_last;
            n_o_status   = r_status;
            n_pend_v     = 1'b0;
            n_state      = S_IDLE;
        end
    end

    // Memory port control: push writes at the count, read follows the new top.
    assign mem_we = do_push;
    assign mem_wa = r_count[AW-1:0];
    assign mem_wd = r_sym;
    assign cnt_m1 = n_count - CW'(1);
    assign mem_ra = (n_count == '0) ? '0 : cnt_m1[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_q  <= mem[mem_ra];
        r_fwd   <= mem_we && (mem_wa == mem_ra);
        r_fwd_d <= mem_wd;
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= P_MAIN;
            r_count   <= '0;
            r_paren   <= '0;
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_paren   <= n_paren;
            r_pend_v  <= n_pend_v;
            r_o_valid <= n_o_valid;
        end
        r_sym        <= n_sym;
        r_last       <= n_last;
        r_status     <= n_status;
        r_pend_c     <= n_pend_c;
        r_o_char     <= n_o_char;
        r_o_has      <= n_o_has;
        r_o_run_last <= n_o_run_last;
        r_o_end      <= n_o_end;
        r_o_status   <= n_o_status;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_char  = r_o_char;
    assign o_has_char  = r_o_has;
    assign o_run_last  = r_o_run_last;
    assign o_expr_end  = r_o_end;
    assign o_status    = r_o_status;

endmodule

`default_nettype wire
